// ===== rtl/core/podi_pkg.sv =====
// ----------------------------------------------------------------------------
// podi_pkg
// Shared types and constants of the planar odometry integrator: request
// structs, register indexes, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package podi_pkg;

  // cordic iteration count: default and upper bound of the arctangent table
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 30;
  localparam int unsigned StepCntW       = 5;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgDeadbandLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDeadbandHigh = 1'b1;

  // register reset values, about -0.005 rad/s and zero in q3.12
  localparam logic signed [15:0] DeadbandLowRst  = -16'sd20;
  localparam logic signed [15:0] DeadbandHighRst = 16'sd0;

  // cordic start vector x component in q30, prescaled by the inverse gain
  localparam logic signed [33:0] CordicStart = 34'sd652032874;

  // radians to binary angle, 2^32 / (2 pi) rounded
  localparam logic [29:0] RadToBam = 30'd683565276;

  // input request
  typedef struct packed {
    logic signed [15:0] vel_fwd;
    logic signed [15:0] vel_side;
    logic signed [15:0] yaw_rate_raw;
    logic        [15:0] vel_interval;
    logic        [15:0] loop_interval;
  } in_req_t;

  // output request
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [15:0] yaw_rate_filtered;
  } out_req_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [29:0] atan_entry(input logic [StepCntW-1:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd536870912;
      5'd1:    val = 30'd316933406;
      5'd2:    val = 30'd167458907;
      5'd3:    val = 30'd85004756;
      5'd4:    val = 30'd42667331;
      5'd5:    val = 30'd21354465;
      5'd6:    val = 30'd10679838;
      5'd7:    val = 30'd5340245;
      5'd8:    val = 30'd2670163;
      5'd9:    val = 30'd1335087;
      5'd10:   val = 30'd667544;
      5'd11:   val = 30'd333772;
      5'd12:   val = 30'd166886;
      5'd13:   val = 30'd83443;
      5'd14:   val = 30'd41722;
      5'd15:   val = 30'd20861;
      5'd16:   val = 30'd10430;
      5'd17:   val = 30'd5215;
      5'd18:   val = 30'd2608;
      5'd19:   val = 30'd1304;
      5'd20:   val = 30'd652;
      5'd21:   val = 30'd326;
      5'd22:   val = 30'd163;
      5'd23:   val = 30'd81;
      5'd24:   val = 30'd41;
      5'd25:   val = 30'd20;
      5'd26:   val = 30'd10;
      5'd27:   val = 30'd5;
      5'd28:   val = 30'd3;
      5'd29:   val = 30'd1;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/planar_odometry_integrator.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// 2d dead reckoning: deadband on the yaw rate, iterative cordic for the
// heading, bit-serial multiplies for the rotated and scaled displacement,
// saturating position and wrapping heading accumulators.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  in        in_valid_i, in_stall_o, in_req_i          request in
//  out       out_valid_o, out_stall_i, out_req_o       request out
//  cfg       cfg_we_i, cfg_index_i, cfg_data_i         write only
//
//  one request at a time: an accepted request passes the cordic loop (one
//  step a cycle), a serial multiply by the velocities and the loop interval,
//  a serial multiply by the velocity interval and by the radian-to-angle scale.
//  reset clears the accumulators to zero and loads the deadband defaults.
//  a stalled result sits in the output register while the next request is
//  worked on; that request waits before its update until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = podi_pkg::CordicStepsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire podi_pkg::in_req_t                   in_req_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      podi_pkg::out_req_t                  out_req_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [podi_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic signed [podi_pkg::CfgDataW-1:0] cfg_data_i
);

  import podi_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROT    = 3'd1;
  localparam logic [2:0] S_MIX    = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;

  localparam logic [StepCntW-1:0] RotLast   = StepCntW'(CORDIC_STEPS - 1);
  localparam logic [StepCntW-1:0] MixFirst  = StepCntW'(15);
  localparam logic [StepCntW-1:0] ScaleFirst = StepCntW'(29);

  logic [2:0]              state_q, state_d;
  logic [StepCntW-1:0]     cnt_q, cnt_d;
  logic signed [33:0]      x_q, x_d, y_q, y_d, z_q, z_d;
  logic                    flip_q, flip_d;
  logic [15:0]             vx_sh_q, vx_sh_d, vy_sh_q, vy_sh_d, ldt_sh_q, ldt_sh_d;
  logic [29:0]             vdt_sh_q, vdt_sh_d;
  logic signed [15:0]      rate_q, rate_d;
  logic signed [47:0]      ax_q, ax_d, ay_q, ay_d;
  logic signed [32:0]      ah_q, ah_d;
  logic signed [63:0]      rx_q, rx_d, ry_q, ry_d, hd_q, hd_d;
  logic signed [21:0]      dx_q, dx_d, dy_q, dy_d;
  logic [31:0]             dth_q, dth_d;
  logic signed [31:0]      xacc_q, xacc_d, yacc_q, yacc_d;
  logic [31:0]             hacc_q, hacc_d;
  logic signed [15:0]      dbl_q, dbl_d, dbh_q, dbh_d;
  logic                    out_valid_q, out_valid_d;
  out_req_t                out_q, out_d;

  logic                    in_fire;

  // position add with clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [21:0] d);
    logic signed [33:0] sum;
    logic signed [31:0] res;
    sum = {{2{acc[31]}}, acc} + {{12{d[21]}}, d};
    if (sum > 34'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (sum < -34'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // sequencer and datapath
  always_comb begin
    logic [31:0]        hsum;
    logic               flip;
    logic [31:0]        hfold;
    logic signed [15:0] raw;
    logic signed [33:0] sx, sy, at, xn, yn;
    logic signed [47:0] cx, sy48, t_vx_c, t_vx_s, t_vy_c, t_vy_s;
    logic               first;
    logic signed [63:0] rxr, ryr, hr;

    state_d    = state_q;
    cnt_d      = cnt_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    flip_d     = flip_q;
    vx_sh_d    = vx_sh_q;
    vy_sh_d    = vy_sh_q;
    ldt_sh_d   = ldt_sh_q;
    vdt_sh_d   = vdt_sh_q;
    rate_d     = rate_q;
    ax_d       = ax_q;
    ay_d       = ay_q;
    ah_d       = ah_q;
    rx_d       = rx_q;
    ry_d       = ry_q;
    hd_d       = hd_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    dth_d      = dth_q;
    xacc_d     = xacc_q;
    yacc_d     = yacc_q;
    hacc_d     = hacc_q;
    out_valid_d = out_valid_q;
    out_d      = out_q;

    // heading fold into the right half plane
    hsum  = hacc_q + 32'h4000_0000;
    flip  = hsum[31];
    hfold = {hacc_q[31] ^ flip, hacc_q[30:0]};

    // deadband on the raw rate
    raw = in_req_i.yaw_rate_raw;

    // cordic step terms
    sx = y_q >>> cnt_q;
    sy = x_q >>> cnt_q;
    at = {4'b0000, atan_entry(cnt_q)};
    if (!z_q[33]) begin
      xn = x_q - sx;
      yn = y_q + sy;
    end else begin
      xn = x_q + sx;
      yn = y_q - sy;
    end

    // serial multiply terms, sign bit weighs negative on the first cycle
    first  = (cnt_q == MixFirst);
    cx     = {{14{x_q[33]}}, x_q};
    sy48   = {{14{y_q[33]}}, y_q};
    t_vx_c = vx_sh_q[15] ? (first ? -cx : cx) : 48'sd0;
    t_vx_s = vx_sh_q[15] ? (first ? -sy48 : sy48) : 48'sd0;
    t_vy_c = vy_sh_q[15] ? (first ? -cx : cx) : 48'sd0;
    t_vy_s = vy_sh_q[15] ? (first ? -sy48 : sy48) : 48'sd0;

    // rounding to q16 and to binary angle
    rxr = rx_q + (64'sd1 <<< 41);
    ryr = ry_q + (64'sd1 <<< 41);
    hr  = hd_q + (64'sd1 <<< 27);

    // output register drains on its own handshake
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          flip_d   = flip;
          x_d      = CordicStart;
          y_d      = 34'sd0;
          z_d      = {{2{hfold[31]}}, hfold};
          vx_sh_d  = in_req_i.vel_fwd;
          vy_sh_d  = in_req_i.vel_side;
          ldt_sh_d = in_req_i.loop_interval;
          vdt_sh_d = {14'd0, in_req_i.vel_interval};
          rate_d   = (raw > dbl_q && raw < dbh_q) ? 16'sd0 : raw;
          ax_d     = 48'sd0;
          ay_d     = 48'sd0;
          ah_d     = 33'sd0;
          rx_d     = 64'sd0;
          ry_d     = 64'sd0;
          hd_d     = 64'sd0;
          cnt_d    = '0;
          state_d  = S_ROT;
        end
      end
      S_ROT: begin
        z_d = z_q[33] ? (z_q + at) : (z_q - at);
        if (cnt_q == RotLast) begin
          x_d     = flip_q ? -xn : xn;
          y_d     = flip_q ? -yn : yn;
          cnt_d   = MixFirst;
          state_d = S_MIX;
        end else begin
          x_d   = xn;
          y_d   = yn;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MIX: begin
        ax_d     = (ax_q <<< 1) + t_vx_c - t_vy_s;
        ay_d     = (ay_q <<< 1) + t_vx_s + t_vy_c;
        ah_d     = (ah_q <<< 1) + (ldt_sh_q[15] ? {{17{rate_q[15]}}, rate_q} : 33'sd0);
        vx_sh_d  = {vx_sh_q[14:0], 1'b0};
        vy_sh_d  = {vy_sh_q[14:0], 1'b0};
        ldt_sh_d = {ldt_sh_q[14:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = ScaleFirst;
          state_d = S_SCALE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SCALE: begin
        rx_d = (rx_q <<< 1) + (vdt_sh_q[29] ? {{16{ax_q[47]}}, ax_q} : 64'sd0);
        ry_d = (ry_q <<< 1) + (vdt_sh_q[29] ? {{16{ay_q[47]}}, ay_q} : 64'sd0);
        hd_d = (hd_q <<< 1) + (RadToBam[cnt_q] ? {{31{ah_q[32]}}, ah_q} : 64'sd0);
        vdt_sh_d = {vdt_sh_q[28:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = S_ROUND;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ROUND: begin
        dx_d    = rxr[63:42];
        dy_d    = ryr[63:42];
        dth_d   = hr[59:28];
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (!out_valid_q || !out_stall_i) begin
          xacc_d  = sat_add(xacc_q, dx_q);
          yacc_d  = sat_add(yacc_q, dy_q);
          hacc_d  = hacc_q + dth_q;
          out_d.pos_x             = sat_add(xacc_q, dx_q);
          out_d.pos_y             = sat_add(yacc_q, dy_q);
          out_d.heading           = hacc_q + dth_q;
          out_d.yaw_rate_filtered = rate_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // deadband register writes
  always_comb begin
    dbl_d = dbl_q;
    dbh_d = dbh_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDeadbandLow:  dbl_d = cfg_data_i;
        CfgDeadbandHigh: dbh_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      xacc_q      <= '0;
      yacc_q      <= '0;
      hacc_q      <= '0;
      dbl_q       <= DeadbandLowRst;
      dbh_q       <= DeadbandHighRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      xacc_q      <= xacc_d;
      yacc_q      <= yacc_d;
      hacc_q      <= hacc_d;
      dbl_q       <= dbl_d;
      dbh_q       <= dbh_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    flip_q   <= flip_d;
    vx_sh_q  <= vx_sh_d;
    vy_sh_q  <= vy_sh_d;
    ldt_sh_q <= ldt_sh_d;
    vdt_sh_q <= vdt_sh_d;
    rate_q   <= rate_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    ah_q     <= ah_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    hd_q     <= hd_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    dth_q    <= dth_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire
